/* sv/prf_pkg.sv */
package prf_pkg;

  // Coordinate format
  localparam int FRAC_BITS = 32;
  localparam int POS_W     = 40;
  localparam int DIFF_W    = POS_W + 1;

  // Configuration
  localparam int CUT_W  = 31;
  localparam int MASS_W = 16;
  localparam logic [CUT_W-1:0]  CUTOFF_RST  = 31'd42949673;
  localparam logic [CUT_W-1:0]  MINRAD_RST  = 31'd429497;
  localparam logic [MASS_W-1:0] INVMASS_RST = 16'd100;

  // Configuration register indexes
  localparam logic [1:0] REG_CUTOFF  = 2'd0;
  localparam logic [1:0] REG_MINRAD  = 2'd1;
  localparam logic [1:0] REG_INVMASS = 2'd2;

  // Square root unit
  localparam int SQ_IN_W  = 64;
  localparam int ROOT_W   = 32;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  // Divider unit: numerator is |r-C| * |d| * inverse_mass, scaled by 2^(FRAC+16)
  localparam int FORCE_SH = FRAC_BITS + 16;
  localparam int NUM_W    = ROOT_W + CUT_W + MASS_W;
  localparam int DVD_W    = NUM_W + FORCE_SH;
  localparam int DEN_W    = 95;
  localparam int Q_W      = 64;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // Statistics
  localparam int RATIO_W = 17;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

  // Stream payloads
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 232;

  typedef struct packed {
    logic ld_in;
    logic do_abs;
    logic do_sq;
    logic do_sum;
    logic do_cmp;
    logic do_rsel;
    logic do_diff;
    logic do_mul1;
    logic do_mul2;
    logic div_go;
    logic do_sat;
    logic do_fin;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic sqrt_busy;
    logic div_busy;
  } sts_t;

endpackage

/* sv/prf_sqrt.sv */
module prf_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [prf_pkg::SQ_IN_W-1:0] radicand,
  output logic [prf_pkg::ROOT_W-1:0]  root,
  output logic                        busy
);

  logic [prf_pkg::SQ_IN_W-1:0]  rad_r, rad_nxt;
  logic [prf_pkg::ROOT_W+2:0]   rem_r, rem_nxt;
  logic [prf_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [prf_pkg::SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic [prf_pkg::ROOT_W+2:0]   rem_sh, trial;

  // One result bit per cycle, two radicand bits in
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_sh   = {rem_r[prf_pkg::ROOT_W:0], rad_r[prf_pkg::SQ_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[prf_pkg::SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[prf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[prf_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == prf_pkg::SQ_CNT_W'(prf_pkg::ROOT_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign busy = busy_r;

endmodule

/* sv/prf_div.sv */
module prf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [prf_pkg::DVD_W-1:0] dividend,
  input  logic [prf_pkg::DEN_W-1:0] divisor,
  output logic [prf_pkg::Q_W-1:0]   quotient,
  output logic                      ovf,
  output logic                      busy
);

  logic [prf_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [prf_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [prf_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [prf_pkg::Q_W-1:0]       q_r, q_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [prf_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [prf_pkg::DEN_W:0]       rem_sh, rem_sub;

  // Restoring division, one quotient bit per cycle; flag bits above the quotient
  always_comb begin
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_sh   = {rem_r, dvd_r[prf_pkg::DVD_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    if (start) begin
      dvd_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[prf_pkg::DVD_W-2:0], 1'b0};
      ovf_nxt = ovf_r | q_r[prf_pkg::Q_W-1];
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[prf_pkg::DEN_W-1:0];
        q_nxt   = {q_r[prf_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[prf_pkg::DEN_W-1:0];
        q_nxt   = {q_r[prf_pkg::Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == prf_pkg::DIV_CNT_W'(prf_pkg::DVD_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quotient = q_r;
  assign ovf      = ovf_r;
  assign busy     = busy_r;

endmodule

/* sv/prf_datapath.sv */
module prf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_op,
  input  logic [prf_pkg::POS_W-1:0]      particle_x,
  input  logic [prf_pkg::POS_W-1:0]      particle_y,
  input  logic [prf_pkg::POS_W-1:0]      neighbor_x,
  input  logic [prf_pkg::POS_W-1:0]      neighbor_y,
  input  logic [prf_pkg::CUT_W-1:0]      cutoff,
  input  logic [prf_pkg::CUT_W-1:0]      minrad,
  input  logic [prf_pkg::MASS_W-1:0]     inv_mass,
  input  prf_pkg::cmd_t                  cmd,
  output prf_pkg::sts_t                  sts,
  output logic [prf_pkg::OUT_DATA_W-1:0] out_data
);

  localparam int DW = prf_pkg::DIFF_W;
  localparam int CW = prf_pkg::CUT_W;
  localparam int RW = prf_pkg::ROOT_W;
  localparam int QW = prf_pkg::Q_W;

  logic          op_r;
  logic [DW-1:0] dx_r, dy_r, ax_r, ay_r;
  logic          small_r, sx_r, sy_r;
  logic [2*CW-1:0] ax2_r, ay2_r, c2_r, m2_r;
  logic [CW-1:0] m_r;
  logic [2*CW:0] r2_r, r2f_r;
  logic          inr_r, gt_r, rok_r;
  logic [RW-1:0] r_r, s_r, diff_r;
  logic          negx_r, negy_r;
  logic [RW+CW-1:0] pdx_r, pdy_r;
  logic [2*RW-1:0]  dlo_r;
  logic [RW+CW-1:0] dhi_r;
  logic [prf_pkg::NUM_W-1:0] numx_r, numy_r;
  logic [prf_pkg::DEN_W-1:0] den_r;
  logic [QW-1:0] magx_r, magy_r;

  logic [prf_pkg::RATIO_W-1:0] min_r, min_nxt;
  logic [prf_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [prf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [prf_pkg::OUT_DATA_W-1:0] out_r;

  logic [RW-1:0] root;
  logic          sqrt_busy;
  logic [QW-1:0] qx, qy, qr;
  logic          ovx, ovy, ovr, bx, by, br;
  logic [QW-1:0] limx, limy;
  logic [QW-1:0] fx, fy;
  logic          inr_eff, upd;
  logic [prf_pkg::RATIO_W-1:0] ratio;
  logic [prf_pkg::SUM_W:0]     sum_add;
  logic [prf_pkg::DVD_W-1:0]   dvd_x, dvd_y, dvd_r;

  // Pipeline of the pair evaluation, one step per controller command
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r <= in_op;
      dx_r <= {neighbor_x[prf_pkg::POS_W-1], neighbor_x} -
              {particle_x[prf_pkg::POS_W-1], particle_x};
      dy_r <= {neighbor_y[prf_pkg::POS_W-1], neighbor_y} -
              {particle_y[prf_pkg::POS_W-1], particle_y};
    end
    if (cmd.do_abs) begin
      sx_r <= dx_r[DW-1];
      sy_r <= dy_r[DW-1];
      ax_r <= dx_r[DW-1] ? (~dx_r + 1'b1) : dx_r;
      ay_r <= dy_r[DW-1] ? (~dy_r + 1'b1) : dy_r;
    end
    if (cmd.do_sq) begin
      small_r <= (ax_r[DW-1:CW] == '0) && (ay_r[DW-1:CW] == '0);
      ax2_r   <= ax_r[CW-1:0] * ax_r[CW-1:0];
      ay2_r   <= ay_r[CW-1:0] * ay_r[CW-1:0];
      c2_r    <= cutoff * cutoff;
      m2_r    <= (minrad == '0) ? (2*CW)'(1) : minrad * minrad;
      m_r     <= (minrad == '0) ? CW'(1) : minrad;
    end
    if (cmd.do_sum) begin
      r2_r <= {1'b0, ax2_r} + {1'b0, ay2_r};
    end
    if (cmd.do_cmp) begin
      inr_r <= small_r && ({1'b0, c2_r} >= r2_r);
      rok_r <= (r2_r != '0) && (cutoff != '0);
      gt_r  <= r2_r > {1'b0, m2_r};
      r2f_r <= (r2_r > {1'b0, m2_r}) ? r2_r : {1'b0, m2_r};
    end
    if (cmd.do_rsel) begin
      s_r <= root;
      r_r <= gt_r ? root : {1'b0, m_r};
    end
    if (cmd.do_diff) begin
      diff_r <= (r_r >= {1'b0, cutoff}) ? r_r - {1'b0, cutoff} : {1'b0, cutoff} - r_r;
      negx_r <= (r_r < {1'b0, cutoff}) != sx_r;
      negy_r <= (r_r < {1'b0, cutoff}) != sy_r;
    end
    if (cmd.do_mul1) begin
      pdx_r <= diff_r * ax_r[CW-1:0];
      pdy_r <= diff_r * ay_r[CW-1:0];
      dlo_r <= r_r * r2f_r[RW-1:0];
      dhi_r <= r_r * r2f_r[2*CW:RW];
    end
    if (cmd.do_mul2) begin
      numx_r <= pdx_r * inv_mass;
      numy_r <= pdy_r * inv_mass;
      den_r  <= {{(prf_pkg::DEN_W-2*RW){1'b0}}, dlo_r} + {dhi_r, {RW{1'b0}}};
    end
    if (cmd.do_sat) begin
      magx_r <= (ovx || (qx > limx)) ? limx : qx;
      magy_r <= (ovy || (qy > limy)) ? limy : qy;
    end
  end

  assign limx = negx_r ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign limy = negy_r ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};

  // Shared square root of the squared distance
  prf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.do_cmp),
    .radicand ({1'b0, r2_r}),
    .root     (root),
    .busy     (sqrt_busy)
  );

  assign dvd_x = {numx_r, {prf_pkg::FORCE_SH{1'b0}}};
  assign dvd_y = {numy_r, {prf_pkg::FORCE_SH{1'b0}}};
  assign dvd_r = {{(prf_pkg::DVD_W-RW-16){1'b0}}, s_r, 16'b0};

  // Force and ratio divisions run side by side
  prf_div u_div_x (
    .clk (clk), .rst_n (rst_n), .start (cmd.div_go),
    .dividend (dvd_x), .divisor (den_r),
    .quotient (qx), .ovf (ovx), .busy (bx)
  );

  prf_div u_div_y (
    .clk (clk), .rst_n (rst_n), .start (cmd.div_go),
    .dividend (dvd_y), .divisor (den_r),
    .quotient (qy), .ovf (ovy), .busy (by)
  );

  prf_div u_div_r (
    .clk (clk), .rst_n (rst_n), .start (cmd.div_go),
    .dividend (dvd_r), .divisor ({{(prf_pkg::DEN_W-CW){1'b0}}, cutoff}),
    .quotient (qr), .ovf (ovr), .busy (br)
  );

  // Final result and statistics update
  always_comb begin
    inr_eff = !op_r && inr_r;
    upd     = inr_eff && rok_r && !ovr;
    ratio   = qr[prf_pkg::RATIO_W-1:0];
    fx      = inr_eff ? (negx_r ? (~magx_r + 1'b1) : magx_r) : '0;
    fy      = inr_eff ? (negy_r ? (~magy_r + 1'b1) : magy_r) : '0;
    sum_add = {1'b0, sum_r} + {{(prf_pkg::SUM_W+1-prf_pkg::RATIO_W){1'b0}}, ratio};
    min_nxt = min_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (op_r) begin
      min_nxt = prf_pkg::RATIO_ONE;
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (upd) begin
      if (ratio < min_r) min_nxt = ratio;
      sum_nxt = sum_add[prf_pkg::SUM_W] ? '1 : sum_add[prf_pkg::SUM_W-1:0];
      if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= prf_pkg::RATIO_ONE;
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.do_fin) begin
      min_r <= min_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    if (cmd.do_fin) begin
      out_r <= {6'b0, cnt_nxt, sum_nxt, min_nxt, inr_eff, fy, fx};
    end
  end

  assign out_data      = out_r;
  assign sts.op_clear  = op_r;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.div_busy  = bx | by | br;

endmodule

/* sv/prf_ctrl.sv */
module prf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  prf_pkg::sts_t sts,
  output prf_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_RSEL = 4'd6;
  localparam logic [3:0] S_DIFF = 4'd7;
  localparam logic [3:0] S_MUL1 = 4'd8;
  localparam logic [3:0] S_MUL2 = 4'd9;
  localparam logic [3:0] S_DGO  = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_SAT  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       fin_ok;

  assign fin_ok = !ov_r || out_tready;

  // Sequence one transaction through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    ov_nxt    = ov_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        cmd.ld_in = in_tvalid;
        if (in_tvalid) state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.do_abs = 1'b1;
        state_nxt  = sts.op_clear ? S_FIN : S_SQ;
      end
      S_SQ:   begin cmd.do_sq  = 1'b1; state_nxt = S_SUM; end
      S_SUM:  begin cmd.do_sum = 1'b1; state_nxt = S_CMP; end
      S_CMP:  begin cmd.do_cmp = 1'b1; state_nxt = S_SQRT; end
      S_SQRT: begin
        if (!sts.sqrt_busy) state_nxt = S_RSEL;
      end
      S_RSEL: begin cmd.do_rsel = 1'b1; state_nxt = S_DIFF; end
      S_DIFF: begin cmd.do_diff = 1'b1; state_nxt = S_MUL1; end
      S_MUL1: begin cmd.do_mul1 = 1'b1; state_nxt = S_MUL2; end
      S_MUL2: begin cmd.do_mul2 = 1'b1; state_nxt = S_DGO; end
      S_DGO:  begin cmd.div_go  = 1'b1; state_nxt = S_DIV; end
      S_DIV: begin
        if (!sts.div_busy) state_nxt = S_SAT;
      end
      S_SAT:  begin cmd.do_sat = 1'b1; state_nxt = S_FIN; end
      S_FIN: begin
        if (fin_ok) begin
          cmd.do_fin = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;

endmodule

/* sv/pairwise_repulsive_force.sv */
// A pair evaluation runs a bit-serial square root and then a bit-serial
// divider between accept and out_tvalid; a clear operation skips both.
// Throughput: one transaction in flight; the next is accepted the cycle after
// the result is registered, while that result may still wait for out_tready.
// Reset (rst_n low, synchronous): control idle, statistics cleared, registers at defaults.
module pairwise_repulsive_force (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // particle_x, particle_y, neighbor_x, neighbor_y
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [231:0] out_tdata,  // force_x, force_y, in_range, min_ratio_out,
                                   // ratio_sum_out, pair_count_out, zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  logic [prf_pkg::CUT_W-1:0]  cutoff_r, minrad_r;
  logic [prf_pkg::MASS_W-1:0] invmass_r;
  prf_pkg::cmd_t cmd;
  prf_pkg::sts_t sts;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= prf_pkg::CUTOFF_RST;
      minrad_r  <= prf_pkg::MINRAD_RST;
      invmass_r <= prf_pkg::INVMASS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        prf_pkg::REG_CUTOFF:  cutoff_r  <= cfg_wdata;
        prf_pkg::REG_MINRAD:  minrad_r  <= cfg_wdata;
        prf_pkg::REG_INVMASS: invmass_r <= cfg_wdata[prf_pkg::MASS_W-1:0];
        default: ;
      endcase
    end
  end

  prf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  prf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .particle_x (in_tdata[39:0]),
    .particle_y (in_tdata[79:40]),
    .neighbor_x (in_tdata[119:80]),
    .neighbor_y (in_tdata[159:120]),
    .cutoff     (cutoff_r),
    .minrad     (minrad_r),
    .inv_mass   (invmass_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_data   (out_tdata)
  );

endmodule

/* sv/prf_checker.sv */
module prf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [231:0] out_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // One transaction at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted while busy");

  // A result never follows its accept in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too early");

  // Minimum ratio never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[145:129] <= 17'd65536)
    else $error("minimum ratio above one");

  // No counted pairs means cleared statistics
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[225:194] == 32'd0) |->
      (out_tdata[145:129] == 17'd65536) && (out_tdata[193:146] == 48'd0))
    else $error("statistics inconsistent with count");

endmodule

bind pairwise_repulsive_force prf_checker u_prf_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int N_RANDOM  = 730;
  localparam int N_QUIET   = 120;
  localparam int SETTLE    = 400;

  typedef struct {
    logic signed [63:0] fx;
    logic signed [63:0] fy;
    logic               inr;
    logic [16:0]        min_ratio;
    logic [47:0]        sum;
    logic [31:0]        cnt;
  } force_res_t;

  typedef struct {
    logic               op;
    logic signed [39:0] px, py, nx, ny;
    logic               typed;
    force_res_t         want;
  } pair_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;   // particle_x, particle_y, neighbor_x, neighbor_y
  logic         in_tuser;   // op
  logic         out_tvalid;
  logic         out_tready;
  logic [231:0] out_tdata;  // force_x, force_y, in_range, min_ratio_out,
                            // ratio_sum_out, pair_count_out, zero pad
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [30:0]  cfg_wdata;

  // shadow copies of registers and statistics
  longint unsigned cut_q, minrad_q, invmass_q;
  longint unsigned min_ratio_q, sum_q, cnt_q;

  force_res_t expected_forces[$];
  int         n_errors;
  int         n_results;
  int         n_in_range;
  int         n_clears;
  bit         quiet;

  pairwise_repulsive_force u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // one force component: (R - C) * d * m * 2^48 / (R * R2), saturated
  function automatic logic [63:0] force_axis(longint d, longint unsigned r,
                                             longint unsigned r2f);
    longint unsigned diff, ad, mag;
    logic [191:0]    num, den, quo, lim;
    bit              neg;
    diff = (r >= cut_q) ? r - cut_q : cut_q - r;
    neg  = (r < cut_q) != (d < 0);
    ad   = (d < 0) ? -d : d;
    if (diff == 0 || ad == 0 || invmass_q == 0) return 64'd0;
    num = 192'(diff) * 192'(ad) * 192'(invmass_q);
    den = 192'(r) * 192'(r2f);
    quo = (num << prf_pkg::FORCE_SH) / den;
    lim = neg ? (192'd1 << 63) : ((192'd1 << 63) - 1);
    mag = (quo > lim) ? lim[63:0] : quo[63:0];
    return neg ? -mag : mag;
  endfunction

  function automatic force_res_t predict_force(pair_row_t it);
    force_res_t      res;
    longint          dx, dy;
    longint unsigned ax, ay, r2, c2, m, m2, r2f, r, ratio;
    res.fx  = 0;
    res.fy  = 0;
    res.inr = 0;
    if (it.op) begin
      min_ratio_q = 65536;
      sum_q       = 0;
      cnt_q       = 0;
    end else begin
      dx = longint'(it.nx) - longint'(it.px);
      dy = longint'(it.ny) - longint'(it.py);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      c2 = cut_q * cut_q;
      if (ax < (64'd1 << 31) && ay < (64'd1 << 31)) begin
        r2 = ax * ax + ay * ay;
        if (r2 <= c2) begin
          m  = (minrad_q != 0) ? minrad_q : 1;
          m2 = m * m;
          res.inr = 1;
          if (r2 != 0 && cut_q != 0) begin
            ratio = (int_sqrt(r2) << 16) / cut_q;
            if (ratio < min_ratio_q) min_ratio_q = ratio;
            sum_q = sum_q + ratio;
            if (sum_q > 64'hFFFF_FFFF_FFFF) sum_q = 64'hFFFF_FFFF_FFFF;
            if (cnt_q < 64'hFFFF_FFFF) cnt_q++;
          end
          r2f = (r2 > m2) ? r2 : m2;
          r   = int_sqrt(r2f);
          res.fx = force_axis(dx, r, r2f);
          res.fy = force_axis(dy, r, r2f);
        end
      end
    end
    res.min_ratio = min_ratio_q[16:0];
    res.sum       = sum_q[47:0];
    res.cnt       = cnt_q[31:0];
    return res;
  endfunction

  // drive one transaction, hold until accepted, then record the prediction
  task automatic send_pair(pair_row_t it);
    force_res_t pred;
    int         gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {it.ny, it.nx, it.py, it.px};
    do @(posedge clk); while (!in_tready);
    pred = predict_force(it);
    if (it.typed) pred = it.want;
    expected_forces = {expected_forces, pred};
  endtask

  task automatic write_reg(logic [1:0] idx, longint unsigned val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[30:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == prf_pkg::REG_CUTOFF) cut_q = val & 64'h7FFF_FFFF;
    else if (idx == prf_pkg::REG_MINRAD) minrad_q = val & 64'h7FFF_FFFF;
    else invmass_q = val & 64'hFFFF;
    @(posedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (expected_forces.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // a pair near the cutoff or minimum-radius scale, or a fully random one now and then
  function automatic pair_row_t random_pair();
    pair_row_t it;
    longint    span, ox, oy;
    it.typed = 0;
    it.op    = ($urandom_range(0, 29) == 0);
    it.px    = {$urandom, $urandom} ;
    it.py    = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      it.nx = {$urandom, $urandom};
      it.ny = {$urandom, $urandom};
    end else begin
      span = longint'(cut_q) + longint'(cut_q / 4) + 1;
      if ($urandom_range(0, 3) == 0) span = longint'(minrad_q) * 2 + 2;
      ox = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
      oy = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
      if (ox < 0) ox = -((-ox) & 64'h7FFF_FFFF_FFFF);
      it.nx = it.px + ox[39:0];
      it.ny = it.py + oy[39:0];
    end
    return it;
  endfunction

  // sample results and compare against the oldest expectation
  always @(posedge clk) begin
    force_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_forces.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
      end else begin
        e = expected_forces.pop_front();
        if (out_tdata[128]) n_in_range++;
        if (out_tdata[63:0] !== e.fx) begin
          $error("force_x: expected %0d, got %0d", e.fx, $signed(out_tdata[63:0]));
          n_errors++;
        end
        if (out_tdata[127:64] !== e.fy) begin
          $error("force_y: expected %0d, got %0d", e.fy, $signed(out_tdata[127:64]));
          n_errors++;
        end
        if (out_tdata[128] !== e.inr) begin
          $error("in_range: expected %0d, got %0d", e.inr, out_tdata[128]);
          n_errors++;
        end
        if (out_tdata[145:129] !== e.min_ratio) begin
          $error("min_ratio_out: expected %0d, got %0d", e.min_ratio,
                 out_tdata[145:129]);
          n_errors++;
        end
        if (out_tdata[193:146] !== e.sum) begin
          $error("ratio_sum_out: expected %0d, got %0d", e.sum, out_tdata[193:146]);
          n_errors++;
        end
        if (out_tdata[225:194] !== e.cnt) begin
          $error("pair_count_out: expected %0d, got %0d", e.cnt, out_tdata[225:194]);
          n_errors++;
        end
      end
    end
  end

  // result-side backpressure in random bursts
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    pair_row_t       dir_rows[$];
    pair_row_t       it;
    force_res_t      rst_stats;
    longint unsigned phase_cfg[5][3];
    int              p, i;

    n_errors = 0; n_results = 0; n_in_range = 0; n_clears = 0; quiet = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    cut_q = prf_pkg::CUTOFF_RST; minrad_q = prf_pkg::MINRAD_RST;
    invmass_q = prf_pkg::INVMASS_RST;
    min_ratio_q = 65536; sum_q = 0; cnt_q = 0;

    rst_stats.fx = 0; rst_stats.fy = 0; rst_stats.inr = 0;
    rst_stats.min_ratio = 17'd65536; rst_stats.sum = 0; rst_stats.cnt = 0;

    // directed rows: clear, extremes, coincident, near cutoff, inside floor
    it = '{op: 1, px: 0, py: 0, nx: 0, ny: 0, typed: 1, want: rst_stats};
    dir_rows = {dir_rows, it};
    it = '{op: 0, px: 40'sh7F_FFFF_FFFF, py: 40'sh80_0000_0000,
           nx: 40'sh80_0000_0000, ny: 40'sh7F_FFFF_FFFF, typed: 1, want: rst_stats};
    dir_rows = {dir_rows, it};
    it.want.inr = 1;
    it = '{op: 0, px: 40'sh12_3456_789A, py: -40'sd5, nx: 40'sh12_3456_789A,
           ny: -40'sd5, typed: 1, want: it.want};
    dir_rows = {dir_rows, it};
    it.typed = 0;
    it.px = 0; it.py = 0; it.nx = 42949673; it.ny = 0; dir_rows = {dir_rows, it};
    it.nx = 42949674; dir_rows = {dir_rows, it};
    it.nx = 0; it.ny = -42949673; dir_rows = {dir_rows, it};
    it.nx = 1; it.ny = 0; dir_rows = {dir_rows, it};
    it.nx = -300000; it.ny = 300000; dir_rows = {dir_rows, it};
    it.px = 40'sh7F_FFFF_FFFF; it.py = 40'sh80_0000_0000;
    it.nx = 40'sh7F_FFFF_0000; it.ny = 40'sh80_0000_FFFF; dir_rows = {dir_rows, it};
    it.px = -20000000; it.py = 10000000; it.nx = 10000000; it.ny = -5000000;
    dir_rows = {dir_rows, it};
    it.op = 1; dir_rows = {dir_rows, it};
    it.op = 0; it.px = 0; it.py = 0; it.nx = 40'sd2147483647; it.ny = 0;
    dir_rows = {dir_rows, it};

    phase_cfg = '{'{42949673, 429497, 100},
                  '{2147483647, 1, 65535},
                  '{1, 1, 1},
                  '{1000, 5000, 300},
                  '{1048576, 1024, 7}};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) send_pair(dir_rows[k]);

    for (p = 0; p < 5; p++) begin
      drain();
      write_reg(prf_pkg::REG_CUTOFF, phase_cfg[p][0]);
      write_reg(prf_pkg::REG_MINRAD, phase_cfg[p][1]);
      write_reg(prf_pkg::REG_INVMASS, phase_cfg[p][2]);
      // tiny-gap pairs under the largest cutoff drive the force into saturation
      if (p == 1) begin
        it = '{op: 0, px: 0, py: 0, nx: 1, ny: -1, typed: 0, want: rst_stats};
        send_pair(it);
        it.nx = -1; it.ny = 0; send_pair(it);
      end
      for (i = 0; i < N_RANDOM / 5; i++) begin
        if (p == 4 && i >= N_RANDOM / 5 - N_QUIET) quiet = 1;
        it = random_pair();
        if (it.op) n_clears++;
        send_pair(it);
      end
    end

    drain();
    $display("Covered %0d result transactions, %0d in range, %0d statistic clears,",
             n_results, n_in_range, n_clears);
    $display("across five register settings including both extremes.");
    if (n_errors == 0 && expected_forces.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_forces.size() != 0)
        $error("%0d expected results never arrived", expected_forces.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
